### rtl/rqs_pkg.sv
// shared constants, types and codes for the retransmit queue scheduler
`timescale 1ns / 1ps
package rqs_pkg;

    localparam int ENTRIES   = 8;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int BUF_DEPTH = 2 * ENTRIES + 1;
    localparam int BUF_W     = $clog2(BUF_DEPTH + 1);

    typedef enum logic [1:0] {
        LST_FREE  = 2'd0,
        LST_WAIT  = 2'd1,
        LST_READY = 2'd2
    } list_t;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_ENQ  = 3'd0,
        KIND_ACK  = 3'd1,
        KIND_SENT = 3'd2,
        KIND_DONE = 3'd3,
        KIND_TICK = 3'd4
    } kind_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        ok;
        logic [7:0]  byte_out;
        logic [15:0] entry_number;
        logic        done_result;
    } result_t;

endpackage

### rtl/rqs_resbuf.sv
// result buffer: holds the results of one request until they are popped at the output
`timescale 1ns / 1ps
module rqs_resbuf
    import rqs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    clr,
    input  logic    push,
    input  result_t wdata,
    input  logic    pop,
    output result_t rdata,
    output logic    last
);

    result_t          mem_reg [BUF_DEPTH];
    logic [BUF_W-1:0] wr_reg, wr_next;
    logic [BUF_W-1:0] rd_reg, rd_next;

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (clr)
        begin
            wr_next = '0;
            rd_next = '0;
        end
        else
        begin
            if (push)
                wr_next = wr_reg + BUF_W'(1);
            if (pop)
                rd_next = rd_reg + BUF_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !clr)
            mem_reg[wr_reg] <= wdata;
    end

    assign rdata = mem_reg[rd_reg];
    assign last  = (rd_reg + BUF_W'(1)) == wr_reg;

endmodule

### rtl/retransmit_queue_scheduler_top.sv
// retransmit queue scheduler: entry lists, list walker and result sequencing
// results leave one per cycle once the work is done, while the output is taken
// throughput: one request at a time, set by the single list walker that visits
// entries in turn, each in a send and then a move state in the send pass; input
// is not ready until the last result is taken
// reset: all entries on the free list in index order, sequence counter zero
`timescale 1ns / 1ps
module retransmit_queue_scheduler_top
    import rqs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ctrl_char[15:0], retries[23:16], wait_ticks[39:24], ack_result[40], uart_room[48:41]
    input  logic [55:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], byte_out[8:1], entry_number[24:9], done_result[25], busy_res[26]
    output logic [31:0] m_tdata,
    // reply_kind[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_ENQ       = 9'b000000010,
        ST_ACK       = 9'b000000100,
        ST_ACK_REPLY = 9'b000001000,
        ST_TWAIT     = 9'b000010000,
        ST_TREADY    = 9'b000100000,
        ST_TSEND     = 9'b001000000,
        ST_TMOVE     = 9'b010000000,
        ST_EMIT      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    list_t            ent_list_reg [ENTRIES];
    list_t            ent_list_next [ENTRIES];
    logic [IDX_W-1:0] ent_rank_reg [ENTRIES];
    logic [IDX_W-1:0] ent_rank_next [ENTRIES];
    logic [15:0]      ent_type_reg [ENTRIES];
    logic [15:0]      ent_seq_reg [ENTRIES];
    logic [7:0]       ent_retry_reg [ENTRIES];
    logic [15:0]      ent_elap_reg [ENTRIES];
    logic [15:0]      ent_tmo_reg [ENTRIES];

    logic [15:0]      seq_reg, seq_next;
    logic [55:0]      req_reg, req_next;
    logic [7:0]       room_reg, room_next;
    logic [1:0]       cur_list_reg, cur_list_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [15:0]      num_save_reg, num_save_next;

    logic [15:0] req_type;
    logic [7:0]  req_retries;
    logic [15:0] req_wait;
    logic        req_ack;

    assign req_type    = req_reg[15:0];
    assign req_retries = req_reg[23:16];
    assign req_wait    = req_reg[39:24];
    assign req_ack     = req_reg[40];

    // list walker lookup
    logic [1:0]       scan_list;
    logic [CNT_W-1:0] scan_pos;
    logic             hit;
    logic [IDX_W-1:0] sel;

    always_comb
    begin
        scan_list = cur_list_reg;
        scan_pos  = pos_reg;
        if (state_reg == ST_ENQ)
        begin
            scan_list = LST_FREE;
            scan_pos  = '0;
        end
        else if (state_reg == ST_TSEND || state_reg == ST_TMOVE)
        begin
            scan_list = LST_READY;
            scan_pos  = '0;
        end
    end

    always_comb
    begin
        hit = 1'b0;
        sel = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (ent_list_reg[i] == scan_list
                && CNT_W'(ent_rank_reg[i]) == scan_pos)
            begin
                hit = 1'b1;
                sel = IDX_W'(i);
            end
        end
    end

    logic [15:0] sel_type, sel_seq, sel_elap, sel_tmo, elap_inc;
    logic [7:0]  sel_retry, retry_dec;
    logic        timed_out;

    assign sel_type  = ent_type_reg[sel];
    assign sel_seq   = ent_seq_reg[sel];
    assign sel_retry = ent_retry_reg[sel];
    assign sel_elap  = ent_elap_reg[sel];
    assign sel_tmo   = ent_tmo_reg[sel];
    assign elap_inc  = sel_elap + 16'd1;
    assign retry_dec = sel_retry - 8'd1;
    assign timed_out = elap_inc > sel_tmo;

    // sequencer
    logic       mv_en;
    list_t      mv_to;
    logic       wr_en;
    logic       wr_new;
    logic [15:0] wr_elap;
    logic [7:0] wr_retry;
    logic       push;
    result_t    push_data;
    logic       buf_clr, buf_pop, buf_last;
    result_t    buf_rdata;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        seq_next      = seq_reg;
        req_next      = req_reg;
        room_next     = room_reg;
        cur_list_next = cur_list_reg;
        pos_next      = pos_reg;
        num_save_next = num_save_reg;
        mv_en         = 1'b0;
        mv_to         = LST_FREE;
        wr_en         = 1'b0;
        wr_new        = 1'b0;
        wr_elap       = sel_elap;
        wr_retry      = sel_retry;
        push          = 1'b0;
        push_data     = '0;
        buf_clr       = 1'b0;
        buf_pop       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next      = s_tdata;
                    room_next     = s_tdata[48:41];
                    cur_list_next = LST_WAIT;
                    pos_next      = '0;
                    buf_clr       = 1'b1;
                    unique case (opcode_t'(s_tuser))
                        OP_ENQ:  state_next = ST_ENQ;
                        OP_ACK:  state_next = ST_ACK;
                        OP_TICK: state_next = ST_TWAIT;
                        OP_NONE: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ENQ:
            begin
                push           = 1'b1;
                push_data.kind = KIND_ENQ;
                if (hit)
                begin
                    wr_en                  = 1'b1;
                    wr_new                 = 1'b1;
                    mv_en                  = 1'b1;
                    mv_to                  = LST_READY;
                    seq_next               = seq_reg + 16'd1;
                    push_data.ok           = 1'b1;
                    push_data.entry_number = seq_reg;
                end
                state_next = ST_EMIT;
            end
            ST_ACK:
            begin
                if (!hit)
                begin
                    if (cur_list_reg == LST_WAIT)
                    begin
                        cur_list_next = LST_READY;
                        pos_next      = '0;
                    end
                    else
                    begin
                        push           = 1'b1;
                        push_data.kind = KIND_ACK;
                        state_next     = ST_EMIT;
                    end
                end
                else if (sel_type == req_type && sel_retry != 8'd0)
                begin
                    mv_en                  = 1'b1;
                    mv_to                  = LST_FREE;
                    push                   = 1'b1;
                    push_data.kind         = KIND_DONE;
                    push_data.entry_number = sel_seq;
                    push_data.done_result  = req_ack;
                    num_save_next          = sel_seq;
                    state_next             = ST_ACK_REPLY;
                end
                else
                    pos_next = pos_reg + CNT_W'(1);
            end
            ST_ACK_REPLY:
            begin
                push                   = 1'b1;
                push_data.kind         = KIND_ACK;
                push_data.ok           = 1'b1;
                push_data.entry_number = num_save_reg;
                state_next             = ST_EMIT;
            end
            ST_TWAIT:
            begin
                if (!hit)
                begin
                    cur_list_next = LST_READY;
                    pos_next      = '0;
                    state_next    = ST_TREADY;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_elap = elap_inc;
                    if (timed_out)
                    begin
                        wr_elap  = '0;
                        wr_retry = retry_dec;
                        mv_en    = 1'b1;
                        if (retry_dec == 8'd0)
                        begin
                            mv_to                  = LST_FREE;
                            push                   = 1'b1;
                            push_data.kind         = KIND_DONE;
                            push_data.entry_number = sel_seq;
                            push_data.done_result  = 1'b1;
                        end
                        else
                            mv_to = LST_READY;
                    end
                    else
                        pos_next = pos_reg + CNT_W'(1);
                end
            end
            ST_TREADY:
            begin
                if (!hit)
                    state_next = ST_TSEND;
                else
                begin
                    wr_en   = 1'b1;
                    wr_elap = elap_inc;
                    if (timed_out && sel_retry == 8'd0)
                    begin
                        // out of retries: expires without advancing the position
                        wr_elap                = '0;
                        mv_en                  = 1'b1;
                        mv_to                  = LST_FREE;
                        push                   = 1'b1;
                        push_data.kind         = KIND_DONE;
                        push_data.entry_number = sel_seq;
                        push_data.done_result  = 1'b1;
                    end
                    else
                    begin
                        if (timed_out)
                        begin
                            wr_elap  = '0;
                            wr_retry = retry_dec;
                        end
                        pos_next = pos_reg + CNT_W'(1);
                    end
                end
            end
            ST_TSEND:
            begin
                if (!hit)
                begin
                    push           = 1'b1;
                    push_data.kind = KIND_TICK;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    if (room_reg != 8'd0)
                    begin
                        room_next              = room_reg - 8'd1;
                        push                   = 1'b1;
                        push_data.kind         = KIND_SENT;
                        push_data.byte_out     = sel_type[7:0];
                        push_data.entry_number = sel_seq;
                    end
                    state_next = ST_TMOVE;
                end
            end
            ST_TMOVE:
            begin
                mv_en = 1'b1;
                if (sel_retry != 8'd0)
                begin
                    wr_en   = 1'b1;
                    wr_elap = '0;
                    mv_to   = LST_WAIT;
                end
                else
                begin
                    mv_to                  = LST_FREE;
                    push                   = 1'b1;
                    push_data.kind         = KIND_DONE;
                    push_data.entry_number = sel_seq;
                end
                state_next = ST_TSEND;
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    buf_pop = 1'b1;
                    if (buf_last)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // move of the selected entry to the tail of another list
    logic [CNT_W-1:0] dst_len;

    always_comb
    begin
        dst_len = '0;
        for (int i = 0; i < ENTRIES; i++)
            if (ent_list_reg[i] == mv_to)
                dst_len = dst_len + CNT_W'(1);
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            ent_list_next[i] = ent_list_reg[i];
            ent_rank_next[i] = ent_rank_reg[i];
            if (mv_en)
            begin
                if (IDX_W'(i) == sel)
                begin
                    ent_list_next[i] = mv_to;
                    ent_rank_next[i] = dst_len[IDX_W-1:0];
                end
                else if (ent_list_reg[i] == ent_list_reg[sel]
                         && ent_rank_reg[i] > ent_rank_reg[sel])
                    ent_rank_next[i] = ent_rank_reg[i] - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            seq_reg      <= '0;
            cur_list_reg <= LST_WAIT;
            pos_reg      <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                ent_list_reg[i] <= LST_FREE;
                ent_rank_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            state_reg    <= state_next;
            seq_reg      <= seq_next;
            cur_list_reg <= cur_list_next;
            pos_reg      <= pos_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                ent_list_reg[i] <= ent_list_next[i];
                ent_rank_reg[i] <= ent_rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        room_reg     <= room_next;
        num_save_reg <= num_save_next;
        if (wr_en)
        begin
            if (wr_new)
            begin
                ent_type_reg[sel]  <= req_type;
                ent_seq_reg[sel]   <= seq_reg;
                ent_retry_reg[sel] <= req_retries;
                ent_tmo_reg[sel]   <= req_wait;
                ent_elap_reg[sel]  <= '0;
            end
            else
            begin
                ent_retry_reg[sel] <= wr_retry;
                ent_elap_reg[sel]  <= wr_elap;
            end
        end
    end

    rqs_resbuf u_resbuf (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (buf_clr),
        .push  (push),
        .wdata (push_data),
        .pop   (buf_pop),
        .rdata (buf_rdata),
        .last  (buf_last)
    );

    logic busy;

    always_comb
    begin
        busy = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (ent_list_reg[i] != LST_FREE)
                busy = 1'b1;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_EMIT;
    assign m_tuser  = buf_rdata.kind;
    assign m_tlast  = buf_last;
    assign m_tdata  = {5'd0, busy, buf_rdata.done_result, buf_rdata.entry_number,
                       buf_rdata.byte_out, buf_rdata.ok};

endmodule
